FILE: sv/adsr_pkg.sv
// Shared constants, codes and control structs of the ADSR envelope generator.
package adsr_pkg;

	// Level format: unsigned Q1.FRAC_BITS
	localparam int FRAC_BITS  = 24;
	localparam int COUNT_BITS = 20;
	localparam int MAX_BURST  = 64;

	localparam int LVL_W     = FRAC_BITS + 1;
	localparam int OUT_W     = 16;
	localparam int UP_SH     = FRAC_BITS - OUT_W;
	localparam int OUT_SRC_W = LVL_W - UP_SH;
	localparam int CFG_W     = 20;
	localparam int IDX_W     = 2;
	localparam int CMD_W     = 2;
	localparam int CNT_W     = 7;
	localparam int PHASE_W   = 3;
	localparam int BURST_W   = $clog2(MAX_BURST + 1);
	localparam int DIV_CNT_W = $clog2(LVL_W);

	localparam logic [LVL_W-1:0] ONE_Q = LVL_W'(1) << FRAC_BITS;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 2'd0,
		CMD_START   = 2'd1,
		CMD_RELEASE = 2'd2
	} cmd_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE    = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_DECAY   = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4,
		PH_DONE    = 3'd5
	} phase_t;

	typedef enum logic [IDX_W-1:0] {
		REG_ATTACK  = 2'd0,
		REG_DECAY   = 2'd1,
		REG_SUSTAIN = 2'd2,
		REG_RELEASE = 2'd3
	} reg_idx_t;

	// Which step the shared divider works out
	typedef enum logic [1:0] {
		DS_ATTACK  = 2'd0,
		DS_DECAY   = 2'd1,
		DS_RELEASE = 2'd2
	} div_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic     start_note;
		logic     release_note;
		logic     div_go;
		div_sel_t div_sel;
		logic     step_we;
		div_sel_t step_sel;
		logic     emit;
		logic     last;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_done;
		logic out_free;
	} dp_stat_t;

	// A zero length acts as a length of one
	function automatic logic [COUNT_BITS-1:0] len_of(input logic [COUNT_BITS-1:0] r);
		len_of = (r == '0) ? COUNT_BITS'(1) : r;
	endfunction

endpackage

FILE: sv/adsr_if.sv
// Valid/ready channel interfaces for commands in and envelope samples out.
interface adsr_in_if;
	logic                        valid;
	logic                        ready;
	logic [adsr_pkg::CMD_W-1:0]  cmd;
	logic [adsr_pkg::CNT_W-1:0]  sample_count;

	modport source (output valid, output cmd, output sample_count, input ready);
	modport sink   (input valid, input cmd, input sample_count, output ready);
endinterface

interface adsr_out_if;
	logic                          valid;
	logic                          ready;
	logic [adsr_pkg::OUT_W-1:0]    level;
	logic [adsr_pkg::PHASE_W-1:0]  phase;
	logic                          last;

	modport source (output valid, output level, output phase, output last, input ready);
	modport sink   (input valid, input level, input phase, input last, output ready);
endinterface

FILE: sv/adsr_div.sv
// Restoring divider, one quotient bit per cycle, for the envelope step values.
module adsr_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                go,
	input  logic [adsr_pkg::LVL_W-1:0]          dividend,
	input  logic [adsr_pkg::COUNT_BITS-1:0]     divisor,
	output logic                                done,
	output logic [adsr_pkg::LVL_W-1:0]          quotient
);

	localparam logic [adsr_pkg::DIV_CNT_W-1:0] LAST_IT = adsr_pkg::DIV_CNT_W'(adsr_pkg::LVL_W - 1);

	logic                               busy_q;
	logic                               done_q;
	logic [adsr_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [adsr_pkg::COUNT_BITS-1:0]    rem_q;
	logic [adsr_pkg::LVL_W-1:0]         dq_q;
	logic [adsr_pkg::COUNT_BITS-1:0]    dvs_q;

	logic [adsr_pkg::COUNT_BITS:0]      trial;
	logic [adsr_pkg::COUNT_BITS:0]      diff;
	logic                               fits;

	// Trial subtraction of one step
	always_comb begin
		trial = {rem_q, dq_q[adsr_pkg::LVL_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= LAST_IT;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[adsr_pkg::COUNT_BITS-1:0] : trial[adsr_pkg::COUNT_BITS-1:0];
			dq_q  <= {dq_q[adsr_pkg::LVL_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

FILE: sv/adsr_dp.sv
// Envelope datapath: configuration, level/phase/position state, steps, output register.
module adsr_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [adsr_pkg::IDX_W-1:0]        cfg_index,
	input  logic [adsr_pkg::CFG_W-1:0]        cfg_data,
	input  adsr_pkg::dp_cmd_t                 cmd,
	output adsr_pkg::dp_stat_t                st,
	adsr_out_if.source                        out_ch
);

	// Configuration registers
	logic [adsr_pkg::COUNT_BITS-1:0] att_len_q;
	logic [adsr_pkg::COUNT_BITS-1:0] dec_len_q;
	logic [adsr_pkg::OUT_W-1:0]      sus_q;
	logic [adsr_pkg::COUNT_BITS-1:0] rel_len_q;

	// Envelope state
	adsr_pkg::phase_t                phase_q;
	logic [adsr_pkg::LVL_W-1:0]      lvl_q;
	logic [adsr_pkg::COUNT_BITS-1:0] pos_q;
	logic [adsr_pkg::LVL_W-1:0]      astep_q;
	logic [adsr_pkg::LVL_W-1:0]      dstep_q;
	logic [adsr_pkg::LVL_W-1:0]      rstep_q;

	// Output register
	logic                            out_valid_q;
	logic [adsr_pkg::OUT_W-1:0]      out_level_q;
	logic [adsr_pkg::PHASE_W-1:0]    out_phase_q;
	logic                            out_last_q;

	logic [adsr_pkg::COUNT_BITS-1:0] len_a;
	logic [adsr_pkg::COUNT_BITS-1:0] len_d;
	logic [adsr_pkg::COUNT_BITS-1:0] len_r;
	logic [adsr_pkg::LVL_W-1:0]      sus_lvl;
	logic [adsr_pkg::LVL_W-1:0]      div_num;
	logic [adsr_pkg::COUNT_BITS-1:0] div_den;
	logic                            div_done;
	logic [adsr_pkg::LVL_W-1:0]      div_quo;

	logic [adsr_pkg::LVL_W:0]        sum;
	adsr_pkg::phase_t                ph_n;
	logic [adsr_pkg::LVL_W-1:0]      lvl_n;
	logic [adsr_pkg::COUNT_BITS-1:0] pos_base;
	logic [adsr_pkg::COUNT_BITS-1:0] pos_n;
	logic [adsr_pkg::OUT_SRC_W-1:0]  lvl_hi;
	logic [adsr_pkg::OUT_W-1:0]      lvl_out;

	assign len_a   = adsr_pkg::len_of(att_len_q);
	assign len_d   = adsr_pkg::len_of(dec_len_q);
	assign len_r   = adsr_pkg::len_of(rel_len_q);
	assign sus_lvl = adsr_pkg::LVL_W'(sus_q) << adsr_pkg::UP_SH;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_len_q <= adsr_pkg::COUNT_BITS'(1);
			dec_len_q <= adsr_pkg::COUNT_BITS'(1);
			sus_q     <= '1;
			rel_len_q <= adsr_pkg::COUNT_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				adsr_pkg::REG_ATTACK:  att_len_q <= cfg_data[adsr_pkg::COUNT_BITS-1:0];
				adsr_pkg::REG_DECAY:   dec_len_q <= cfg_data[adsr_pkg::COUNT_BITS-1:0];
				adsr_pkg::REG_SUSTAIN: sus_q     <= cfg_data[adsr_pkg::OUT_W-1:0];
				adsr_pkg::REG_RELEASE: rel_len_q <= cfg_data[adsr_pkg::COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Divider operand select
	always_comb begin
		unique case (cmd.div_sel)
			adsr_pkg::DS_ATTACK: begin
				div_num = adsr_pkg::ONE_Q;
				div_den = len_a;
			end
			adsr_pkg::DS_DECAY: begin
				div_num = adsr_pkg::ONE_Q - sus_lvl;
				div_den = len_d;
			end
			default: begin
				div_num = lvl_q;
				div_den = len_r;
			end
		endcase
	end

	adsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// One envelope sample: level and phase update, then position advance
	always_comb begin
		sum      = {1'b0, lvl_q} + {1'b0, astep_q};
		ph_n     = phase_q;
		lvl_n    = '0;
		pos_base = pos_q;
		unique case (phase_q)
			adsr_pkg::PH_ATTACK: begin
				lvl_n = (sum > {1'b0, adsr_pkg::ONE_Q}) ? adsr_pkg::ONE_Q
				                                        : sum[adsr_pkg::LVL_W-1:0];
				if (pos_q >= len_a) begin
					ph_n     = adsr_pkg::PH_DECAY;
					pos_base = '0;
				end
			end
			adsr_pkg::PH_DECAY: begin
				lvl_n = (lvl_q >= dstep_q) ? lvl_q - dstep_q : '0;
				if (pos_q >= len_d) begin
					ph_n     = adsr_pkg::PH_SUSTAIN;
					pos_base = '0;
				end
			end
			adsr_pkg::PH_SUSTAIN: begin
				lvl_n = sus_lvl;
			end
			adsr_pkg::PH_RELEASE: begin
				lvl_n = (lvl_q >= rstep_q) ? lvl_q - rstep_q : '0;
				if (pos_q >= len_r) begin
					ph_n = adsr_pkg::PH_DONE;
				end
			end
			default: begin
				lvl_n = '0;
			end
		endcase
		pos_n   = (&pos_base) ? pos_base : pos_base + 1'b1;
		lvl_hi  = lvl_n[adsr_pkg::LVL_W-1:adsr_pkg::UP_SH];
		lvl_out = (|lvl_hi[adsr_pkg::OUT_SRC_W-1:adsr_pkg::OUT_W]) ? '1
		                                                          : lvl_hi[adsr_pkg::OUT_W-1:0];
	end

	// Envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= adsr_pkg::PH_IDLE;
			lvl_q   <= '0;
			pos_q   <= '0;
			astep_q <= '0;
			dstep_q <= '0;
			rstep_q <= '0;
		end else begin
			if (cmd.start_note) begin
				phase_q <= adsr_pkg::PH_ATTACK;
				lvl_q   <= '0;
				pos_q   <= '0;
			end else if (cmd.release_note) begin
				phase_q <= adsr_pkg::PH_RELEASE;
				pos_q   <= '0;
			end else if (cmd.emit) begin
				phase_q <= ph_n;
				lvl_q   <= lvl_n;
				pos_q   <= pos_n;
			end
			if (cmd.step_we) begin
				unique case (cmd.step_sel)
					adsr_pkg::DS_ATTACK: astep_q <= div_quo;
					adsr_pkg::DS_DECAY:  dstep_q <= div_quo;
					default:             rstep_q <= div_quo;
				endcase
			end
		end
	end

	// Output register: filled on a sample, emptied on a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_level_q <= lvl_out;
			out_phase_q <= ph_n;
			out_last_q  <= cmd.last;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.level = out_level_q;
	assign out_ch.phase = out_phase_q;
	assign out_ch.last  = out_last_q;

	assign st.div_done = div_done;
	assign st.out_free = !out_valid_q || out_ch.ready;

	// Level never leaves [0, 1.0]
	a_lvl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= adsr_pkg::ONE_Q)
		else $error("level accumulator above full scale");

	// Done is only reached from release
	a_done_from_rel: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == adsr_pkg::PH_DONE && $past(phase_q) != adsr_pkg::PH_DONE)
		|-> $past(phase_q) == adsr_pkg::PH_RELEASE)
		else $error("done phase entered from a phase other than release");

endmodule

FILE: sv/adsr_ctrl.sv
// Controller: command decode, divider sequencing and tick burst counting.
module adsr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	adsr_in_if.sink              in_ch,
	input  adsr_pkg::dp_stat_t   st,
	output adsr_pkg::dp_cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_DIV_A = 5'b00010,
		S_DIV_D = 5'b00100,
		S_DIV_R = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t                          state_q;
	state_t                          state_n;
	logic [adsr_pkg::BURST_W-1:0]    rem_q;
	logic [adsr_pkg::BURST_W-1:0]    rem_n;
	logic [adsr_pkg::BURST_W-1:0]    burst_len;

	// Burst length cut to the maximum burst
	assign burst_len = (in_ch.sample_count > adsr_pkg::CNT_W'(adsr_pkg::MAX_BURST))
	                   ? adsr_pkg::BURST_W'(adsr_pkg::MAX_BURST)
	                   : adsr_pkg::BURST_W'(in_ch.sample_count);

	assign in_ch.ready = (state_q == S_IDLE);

	// Next state and datapath commands
	always_comb begin
		cmd      = '0;
		state_n  = state_q;
		rem_n    = rem_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_ch.valid) begin
					unique case (in_ch.cmd)
						adsr_pkg::CMD_START: begin
							cmd.start_note = 1'b1;
							cmd.div_go     = 1'b1;
							cmd.div_sel    = adsr_pkg::DS_ATTACK;
							state_n        = S_DIV_A;
						end
						adsr_pkg::CMD_RELEASE: begin
							cmd.release_note = 1'b1;
							cmd.div_go       = 1'b1;
							cmd.div_sel      = adsr_pkg::DS_RELEASE;
							state_n          = S_DIV_R;
						end
						adsr_pkg::CMD_TICK: begin
							if (burst_len != '0) begin
								rem_n   = burst_len;
								state_n = S_EMIT;
							end
						end
						default: ;
					endcase
				end
			end
			S_DIV_A: begin
				if (st.div_done) begin
					cmd.step_we  = 1'b1;
					cmd.step_sel = adsr_pkg::DS_ATTACK;
					cmd.div_go   = 1'b1;
					cmd.div_sel  = adsr_pkg::DS_DECAY;
					state_n      = S_DIV_D;
				end
			end
			S_DIV_D: begin
				if (st.div_done) begin
					cmd.step_we  = 1'b1;
					cmd.step_sel = adsr_pkg::DS_DECAY;
					state_n      = S_IDLE;
				end
			end
			S_DIV_R: begin
				if (st.div_done) begin
					cmd.step_we  = 1'b1;
					cmd.step_sel = adsr_pkg::DS_RELEASE;
					state_n      = S_IDLE;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = (rem_q == adsr_pkg::BURST_W'(1));
					rem_n    = rem_q - 1'b1;
					if (cmd.last) begin
						state_n = S_IDLE;
					end
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rem_q   <= '0;
		end else begin
			state_q <= state_n;
			rem_q   <= rem_n;
		end
	end

	// A burst in progress always has samples left
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> rem_q != '0)
		else $error("burst state with no samples left");

	// The final sample of a burst returns the controller to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> state_q == S_IDLE)
		else $error("controller did not return to idle after the last sample");

endmodule

FILE: sv/adsr_envelope_generator.sv
// Top level of the linear ADSR envelope generator.
//
// Usage:
//   in_ch  carries commands: cmd 0 emits a burst of sample_count envelope
//          samples (cut to 64; zero gives none), cmd 1 starts a note, cmd 2
//          releases it, cmd 3 is dropped. A command transfers when valid and
//          ready are both high; ready is high only while the controller idles.
//   out_ch carries one sample per transfer: 16-bit level, phase after the
//          sample, and last on the final sample of a burst.
//   cfg_we/cfg_index/cfg_data write the attack, decay, sustain and release
//          registers; write them only while no command is in progress.
// Sequencing:
//   Note start runs two divisions on the one shared restoring divider
//   (attack step, then decay step); release runs one division. A burst
//   leaves one sample per cycle through a single output register while
//   out_ch is not stalled; a stalled receiver holds the burst in place.
// Reset: arst_n clears the phase to idle, the level, position and steps to
//   zero, and the registers to lengths of one and full-scale sustain.
module adsr_envelope_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	adsr_in_if.sink                         in_ch,
	adsr_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [adsr_pkg::IDX_W-1:0]      cfg_index,
	input  logic [adsr_pkg::CFG_W-1:0]      cfg_data
);

	adsr_pkg::dp_cmd_t  dp_cmd;
	adsr_pkg::dp_stat_t dp_stat;

	adsr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.st     (dp_stat),
		.cmd    (dp_cmd)
	);

	adsr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (dp_cmd),
		.st        (dp_stat),
		.out_ch    (out_ch)
	);

endmodule

FILE: tb/sv/adsr_envelope_generator_test.sv
// Self-checking testbench of the ADSR envelope generator against an envelope predictor.
module adsr_envelope_generator_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int SETTLE_CYCLES   = 64;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int HOLD_OFF_AT     = 800;
	localparam int MAX_WAIT        = 6;
	localparam int REPORT_LIMIT    = 10;
	localparam int RANDOM_PHASES   = 8;
	localparam int PHASE_ITEMS     = 44;
	localparam int STEP_W          = adsr_pkg::LVL_W + 1;
	localparam logic [adsr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [adsr_pkg::CMD_W-1:0] cmd;
		logic [adsr_pkg::CNT_W-1:0] count;
	} note_cmd_t;

	typedef struct packed {
		logic [adsr_pkg::OUT_W-1:0] level;
		adsr_pkg::phase_t           phase;
		logic                       last;
	} env_sample_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [adsr_pkg::IDX_W-1:0] cfg_index;
	logic [adsr_pkg::CFG_W-1:0] cfg_data;

	adsr_in_if  in_if();
	adsr_out_if out_if();

	adsr_envelope_generator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_if),
		.out_ch    (out_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Register shadows
	logic [adsr_pkg::CFG_W-1:0] attack_len;
	logic [adsr_pkg::CFG_W-1:0] decay_len;
	logic [adsr_pkg::OUT_W-1:0] sustain_lvl;
	logic [adsr_pkg::CFG_W-1:0] release_len;

	// Envelope state as the block should hold it
	adsr_pkg::phase_t                env_phase;
	logic [adsr_pkg::LVL_W-1:0]      env_level;
	logic [adsr_pkg::COUNT_BITS-1:0] env_pos;
	logic [adsr_pkg::LVL_W-1:0]      attack_inc;
	logic [STEP_W-1:0]               decay_dec;
	logic [STEP_W-1:0]               release_dec;

	note_cmd_t   cmd_queue[$];
	env_sample_t samples_due[$];

	note_cmd_t   head_cmd;
	note_cmd_t   taken_cmd;
	env_sample_t want;
	bit          cmd_taken;
	bit          sample_taken;
	bit          offering;
	bit          steady;
	bit          hold_done;
	int          cmd_gap;
	int          sample_gap;
	int          hold_left;
	int          idle_cycles;
	int          failures;
	int          samples_checked;
	int          tick_total;
	int          start_total;
	int          release_total;
	int          ignored_total;
	int          settings_total;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A zero length counts as one
	function automatic logic [adsr_pkg::COUNT_BITS-1:0] effective_length(
			input logic [adsr_pkg::CFG_W-1:0] r);
		logic [adsr_pkg::COUNT_BITS-1:0] n;
		n = adsr_pkg::COUNT_BITS'(r);
		return (n == '0) ? adsr_pkg::COUNT_BITS'(1) : n;
	endfunction

	function automatic int draw_gap();
		return steady ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	// Apply one command to the envelope state and queue the samples it emits
	task automatic run_envelope(input note_cmd_t nc);
		int                         n;
		int                         i;
		logic [STEP_W-1:0]          sum;
		logic [adsr_pkg::LVL_W-1:0] sus_q;
		env_sample_t                s;
		sus_q = adsr_pkg::LVL_W'(sustain_lvl) << adsr_pkg::UP_SH;
		unique case (nc.cmd)
		adsr_pkg::CMD_START: begin
			env_phase  = adsr_pkg::PH_ATTACK;
			env_level  = '0;
			env_pos    = '0;
			attack_inc = adsr_pkg::ONE_Q / effective_length(attack_len);
			decay_dec  = STEP_W'(adsr_pkg::ONE_Q - sus_q) / effective_length(decay_len);
		end
		adsr_pkg::CMD_RELEASE: begin
			env_phase   = adsr_pkg::PH_RELEASE;
			env_pos     = '0;
			release_dec = STEP_W'(env_level) / effective_length(release_len);
		end
		adsr_pkg::CMD_TICK: begin
			n = (nc.count > adsr_pkg::MAX_BURST) ? adsr_pkg::MAX_BURST : int'(nc.count);
			for (i = 0; i < n; i++) begin
				unique case (env_phase)
				adsr_pkg::PH_ATTACK: begin
					sum = {1'b0, env_level} + STEP_W'(attack_inc);
					env_level = (sum > STEP_W'(adsr_pkg::ONE_Q)) ? adsr_pkg::ONE_Q
						: sum[adsr_pkg::LVL_W-1:0];
					if (env_pos >= effective_length(attack_len)) begin
						env_phase = adsr_pkg::PH_DECAY;
						env_pos   = '0;
					end
				end
				adsr_pkg::PH_DECAY: begin
					env_level = ({1'b0, env_level} >= decay_dec) ?
						env_level - decay_dec[adsr_pkg::LVL_W-1:0] : '0;
					if (env_pos >= effective_length(decay_len)) begin
						env_phase = adsr_pkg::PH_SUSTAIN;
						env_pos   = '0;
					end
				end
				adsr_pkg::PH_SUSTAIN: begin
					env_level = sus_q;
				end
				adsr_pkg::PH_RELEASE: begin
					env_level = ({1'b0, env_level} >= release_dec) ?
						env_level - release_dec[adsr_pkg::LVL_W-1:0] : '0;
					if (env_pos >= effective_length(release_len))
						env_phase = adsr_pkg::PH_DONE;
				end
				default: begin
					env_level = '0;
				end
				endcase
				// full scale saturates
				s.level = env_level[adsr_pkg::FRAC_BITS] ? '1
					: env_level[adsr_pkg::FRAC_BITS-1 -: adsr_pkg::OUT_W];
				s.phase = env_phase;
				s.last  = (i + 1 == n);
				samples_due.push_back(s);
				if (env_pos != '1)
					env_pos++;
			end
		end
		default: begin
		end
		endcase
	endtask

	// Transfers on both channels, checking and watchdog
	always @(posedge clk) begin
		sample_taken = arst_n && out_if.valid && out_if.ready;
		cmd_taken    = arst_n && in_if.valid && in_if.ready;
		if (sample_taken) begin
			if (samples_due.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected sample: level %h phase %0d last %b",
						out_if.level, out_if.phase, out_if.last);
			end else begin
				want = samples_due.pop_front();
				samples_checked++;
				if (out_if.level !== want.level || out_if.phase !== want.phase ||
						out_if.last !== want.last) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display({"sample %0d: expected level %h phase %0d last %b,",
							" got level %h phase %0d last %b"},
							samples_checked, want.level, want.phase, want.last,
							out_if.level, out_if.phase, out_if.last);
				end
			end
		end
		if (cmd_taken) begin
			taken_cmd.cmd   = in_if.cmd;
			taken_cmd.count = in_if.sample_count;
			unique case (taken_cmd.cmd)
			adsr_pkg::CMD_TICK:    tick_total++;
			adsr_pkg::CMD_START:   start_total++;
			adsr_pkg::CMD_RELEASE: release_total++;
			default:               ignored_total++;
			endcase
			run_envelope(taken_cmd);
		end
		if (sample_taken || cmd_taken) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", idle_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Command driver: one item per transfer, random gap after each
	always @(negedge clk) begin
		if (arst_n) begin
			if (cmd_taken) begin
				offering = 1'b0;
				cmd_gap  = draw_gap();
			end
			if (!offering) begin
				if (cmd_gap > 0) begin
					cmd_gap--;
				end else if (cmd_queue.size() > 0) begin
					head_cmd = cmd_queue.pop_front();
					offering = 1'b1;
					in_if.cmd          <= head_cmd.cmd;
					in_if.sample_count <= head_cmd.count;
				end
			end
			in_if.valid <= offering;
		end
	end

	// Sample receiver: random stall per transfer, one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (sample_taken)
				sample_gap = draw_gap();
			if (!hold_done && samples_checked >= HOLD_OFF_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_if.ready <= 1'b0;
			end else if (sample_gap > 0) begin
				sample_gap--;
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	task automatic send_cmd(input logic [adsr_pkg::CMD_W-1:0] c,
			input logic [adsr_pkg::CNT_W-1:0] n);
		note_cmd_t nc;
		nc.cmd   = c;
		nc.count = n;
		cmd_queue.push_back(nc);
	endtask

	task automatic write_reg(input adsr_pkg::reg_idx_t idx,
			input logic [adsr_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		unique case (idx)
		adsr_pkg::REG_ATTACK:  attack_len  = val;
		adsr_pkg::REG_DECAY:   decay_len   = val;
		adsr_pkg::REG_SUSTAIN: sustain_lvl = val[adsr_pkg::OUT_W-1:0];
		adsr_pkg::REG_RELEASE: release_len = val;
		default: begin
		end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [adsr_pkg::CFG_W-1:0] a,
			input logic [adsr_pkg::CFG_W-1:0] d,
			input logic [adsr_pkg::CFG_W-1:0] s, input logic [adsr_pkg::CFG_W-1:0] r);
		write_reg(adsr_pkg::REG_ATTACK, a);
		write_reg(adsr_pkg::REG_DECAY, d);
		write_reg(adsr_pkg::REG_SUSTAIN, s);
		write_reg(adsr_pkg::REG_RELEASE, r);
		settings_total++;
	endtask

	// Drain everything, then let a start or release division finish
	task automatic settle();
		while (cmd_queue.size() != 0 || offering || samples_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [adsr_pkg::CNT_W-1:0] tick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 15)
			return adsr_pkg::CNT_W'($urandom_range(adsr_pkg::MAX_BURST + 1, 127));
		return adsr_pkg::CNT_W'($urandom_range(1, adsr_pkg::MAX_BURST));
	endfunction

	function automatic logic [adsr_pkg::CFG_W-1:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 16)
			return '1;
		if (r < 70)
			return adsr_pkg::CFG_W'($urandom_range(1, 40));
		return adsr_pkg::CFG_W'($urandom_range(41, 3000));
	endfunction

	function automatic logic [adsr_pkg::CFG_W-1:0] pick_sustain();
		int                         r;
		logic [adsr_pkg::OUT_W-1:0] s;
		r = $urandom_range(0, 99);
		if (r < 20)
			s = '0;
		else if (r < 40)
			s = '1;
		else
			s = adsr_pkg::OUT_W'($urandom());
		// upper data bits are don't-care for this register
		return {4'($urandom_range(0, 15)), s};
	endfunction

	initial begin
		int items;
		int k;
		int j;
		logic [adsr_pkg::CMD_W-1:0] c;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		in_if.valid        = 1'b0;
		in_if.cmd          = '0;
		in_if.sample_count = '0;
		out_if.ready       = 1'b0;
		attack_len         = adsr_pkg::CFG_W'(1);
		decay_len          = adsr_pkg::CFG_W'(1);
		sustain_lvl        = '1;
		release_len        = adsr_pkg::CFG_W'(1);
		env_phase          = adsr_pkg::PH_IDLE;
		env_level          = '0;
		env_pos            = '0;
		attack_inc         = '0;
		decay_dec          = '0;
		release_dec        = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Idle output, empty and long bursts, unused command
		send_cmd(adsr_pkg::CMD_TICK, 7'd1);
		send_cmd(adsr_pkg::CMD_TICK, 7'd0);
		send_cmd(CMD_UNUSED, 7'd5);
		send_cmd(adsr_pkg::CMD_TICK, 7'd127);
		// Release from idle runs out into done
		send_cmd(adsr_pkg::CMD_RELEASE, 7'd0);
		send_cmd(adsr_pkg::CMD_TICK, 7'd3);
		send_cmd(adsr_pkg::CMD_TICK, 7'd2);
		// Whole envelope at reset lengths, full-scale sustain
		send_cmd(adsr_pkg::CMD_START, 7'd127);
		send_cmd(adsr_pkg::CMD_TICK, 7'd10);
		send_cmd(adsr_pkg::CMD_RELEASE, 7'd0);
		send_cmd(adsr_pkg::CMD_TICK, 7'd4);
		// Restart in the middle of attack
		send_cmd(adsr_pkg::CMD_START, 7'd0);
		send_cmd(adsr_pkg::CMD_TICK, 7'd1);
		send_cmd(adsr_pkg::CMD_START, 7'd64);
		send_cmd(adsr_pkg::CMD_TICK, 7'd64);
		settle();

		// Zero lengths, zero sustain
		configure('0, '0, '0, '0);
		send_cmd(adsr_pkg::CMD_START, 7'd0);
		send_cmd(adsr_pkg::CMD_TICK, 7'd64);
		send_cmd(adsr_pkg::CMD_RELEASE, 7'd0);
		send_cmd(adsr_pkg::CMD_TICK, 7'd8);
		settle();

		// Longest lengths; release from a partial attack, then release again
		configure('1, '1, 20'hA5A5A, '1);
		send_cmd(adsr_pkg::CMD_START, 7'd0);
		send_cmd(adsr_pkg::CMD_TICK, 7'd64);
		send_cmd(adsr_pkg::CMD_TICK, 7'd64);
		send_cmd(adsr_pkg::CMD_RELEASE, 7'd0);
		send_cmd(adsr_pkg::CMD_TICK, 7'd20);
		send_cmd(adsr_pkg::CMD_RELEASE, 7'd127);
		send_cmd(adsr_pkg::CMD_TICK, 7'd3);
		settle();

		// Random settings, mostly well-formed notes with some noise
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			configure(pick_length(), pick_length(), pick_sustain(), pick_length());
			steady = ($urandom_range(0, 3) == 0);
			items  = 0;
			while (items < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 80) begin
					send_cmd(adsr_pkg::CMD_START, adsr_pkg::CNT_W'($urandom_range(0, 127)));
					k = $urandom_range(1, 6);
					repeat (k) send_cmd(adsr_pkg::CMD_TICK, tick_len());
					send_cmd(adsr_pkg::CMD_RELEASE, adsr_pkg::CNT_W'($urandom_range(0, 127)));
					j = $urandom_range(0, 3);
					repeat (j) send_cmd(adsr_pkg::CMD_TICK, tick_len());
					items += k + j + 2;
				end else begin
					c = adsr_pkg::CMD_W'($urandom_range(0, 3));
					send_cmd(c, adsr_pkg::CNT_W'($urandom_range(0, 127)));
					if (c != CMD_UNUSED)
						items++;
				end
			end
			settle();
		end

		steady = 1'b0;
		settle();
		failures += samples_due.size();
		$display("Run covered %0d ticks, %0d note starts, %0d releases, %0d dropped commands",
			tick_total, start_total, release_total, ignored_total);
		$display("%0d envelope samples checked over %0d register settings, %0d failures",
			samples_checked, settings_total, failures);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
